// ----- hdl/binary_to_decimal_ascii_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII converter.
// The clock and reset in scope must be named clk_i and rst_ni.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B2D_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2D_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/b2d_pkg.sv -----
// ---------------------------------------------------------------------------
// b2d_pkg
// Types, widths and helper functions of the binary to decimal converter.
// ---------------------------------------------------------------------------
`default_nettype none

package b2d_pkg;

  // Port widths of the item fields
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W  = 6;

  // Low bits of value that take part in the conversion (8..64)
  localparam int unsigned VALUE_BITS = 64;

  // Decimal digits of 2^VALUE_BITS - 1: floor(bits * log10(2)) + 1
  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [BCD_W-1:0]      bcd_t;
  typedef logic [VALUE_BITS-1:0] shift_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // Add 3 to every BCD digit of 5 or more, ahead of the next shift
  function automatic bcd_t bcd_adjust(input bcd_t bcd);
    bcd_t res;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // True when every digit is a legal decimal digit
  function automatic logic bcd_legal(input bcd_t bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/b2d_in_if.sv -----
// ---------------------------------------------------------------------------
// b2d_in_if
// Input channel: one binary value per item, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface b2d_in_if import b2d_pkg::*;;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface

`default_nettype wire

// ----- hdl/b2d_out_if.sv -----
// ---------------------------------------------------------------------------
// b2d_out_if
// Output channel: one ASCII digit per item, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface b2d_out_if import b2d_pkg::*;;

  logic  valid;
  logic  ready;
  char_t digit_char;
  logic  last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);

endinterface

`default_nettype wire

// ----- hdl/binary_to_decimal_ascii.sv -----
// Converts one unsigned binary value per input item into its decimal form,
// sent as ASCII digits '0'..'9', most significant first, one per output
// item, leading zeros dropped and the final digit flagged by last_digit.
// Only the low VALUE_BITS bits of value are used. A bit-serial double-dabble
// loop shifts the value in one bit per cycle, then the BCD register unloads
// one digit per cycle while the output register is free, suppressed leading
// zeros included. The converter then returns to idle before it takes the
// next value, so it takes no new value while one is still converting or
// unloading. The last digit may still wait in the output register while the
// next value converts.
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// Bit-serial binary to decimal ASCII converter, top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "binary_to_decimal_ascii_macros.svh"

module binary_to_decimal_ascii import b2d_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  b2d_in_if.sink     in_i,
  b2d_out_if.source  out_o
);

  localparam cnt_t CONV_LAST = cnt_t'(VALUE_BITS - 1);
  localparam cnt_t EMIT_LAST = cnt_t'(NUM_DIGITS - 1);

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;
  shift_t shift_q, shift_d;
  bcd_t   bcd_q, bcd_d;
  logic   leading_q, leading_d;
  logic   out_valid_q, out_valid_d;
  char_t  out_char_q, out_char_d;
  logic   out_last_q, out_last_d;

  logic [3:0] top_digit;
  logic       slot_free;
  logic       is_final;
  bcd_t       bcd_adj;

  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign slot_free = !out_valid_q || out_o.ready;
  assign is_final  = (cnt_q == EMIT_LAST);
  assign bcd_adj   = bcd_adjust(bcd_q);

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last_digit = out_last_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    bcd_d       = bcd_q;
    leading_d   = leading_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          shift_d = in_i.value[VALUE_BITS-1:0];
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        // adjust, then shift the next value bit into the BCD register
        bcd_d   = {bcd_adj[BCD_W-2:0], shift_q[VALUE_BITS-1]};
        shift_d = {shift_q[VALUE_BITS-2:0], 1'b0};
        cnt_d   = cnt_q + cnt_t'(1);
        if (cnt_q == CONV_LAST) begin
          cnt_d     = '0;
          leading_d = 1'b1;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          // drop leading zeros, but always send the final digit
          if (!(leading_q && (top_digit == 4'd0) && !is_final)) begin
            out_valid_d = 1'b1;
            out_char_d  = ASCII_ZERO | {{(CHAR_W-4){1'b0}}, top_digit};
            out_last_d  = is_final;
            leading_d   = 1'b0;
          end
          bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
          cnt_d = cnt_q + cnt_t'(1);
          if (is_final) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      leading_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      leading_q   <= leading_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  `B2D_ASSERT_NXT(a_accept_starts_conv, in_i.valid && in_i.ready, (state_q == ST_CONV) && (cnt_q == '0), "accepted item did not start conversion")
  `B2D_ASSERT_IMP(a_bcd_legal, (state_q == ST_CONV) || (state_q == ST_EMIT), bcd_legal(bcd_q), "illegal BCD digit in conversion register")
  `B2D_ASSERT_IMP(a_digit_ascii, out_valid_q, (out_char_q[CHAR_W-1:4] == 2'b11) && (out_char_q[3:0] <= 4'd9), "output digit outside '0'..'9'")

endmodule

`default_nettype wire

// ----- sim/binary_to_decimal_ascii_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_test
// Self-checking bench for the binary to decimal ASCII converter. A queue of
// values (directed corner values, then a random mix of widths, powers of
// ten and near-maximum values) feeds a valid/ready driver. Each accepted
// value is expanded into its expected decimal digits. Every digit leaving
// the block is checked against the oldest expected digit. Both sides pause
// at random, except during one stretch of items.
// ---------------------------------------------------------------------------

module binary_to_decimal_ascii_test;
  import b2d_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = VALUE_BITS + NUM_DIGITS + 16;
  localparam int unsigned RANDOM_VALUES = 300;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    char_t digit_char;
    logic  last_digit;
  } digit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  b2d_in_if  in_bus ();
  b2d_out_if out_bus ();

  binary_to_decimal_ascii DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  value_t values_queued[$];
  digit_t digits_due[$];

  logic value_taken;
  int unsigned quiet_cycles;
  int unsigned values_taken;
  int unsigned digits_checked;
  int unsigned zero_values;
  int unsigned full_runs;
  int unsigned mismatches;

  always #2 clk_i = ~clk_i;

  // Expected digits of one value, most significant first
  function automatic void expand_decimal(input value_t raw);
    value_t      v;
    logic [3:0]  dec[NUM_DIGITS];
    int          n;
    digit_t      d;
    v = raw & ~(value_t'('1) << VALUE_BITS);
    n = 0;
    if (v == '0) begin
      dec[0] = 4'd0;
      n = 1;
      zero_values++;
    end
    while (v != '0 && n < NUM_DIGITS) begin
      dec[n] = 4'(v % 10);
      v = v / 10;
      n++;
    end
    if (n == NUM_DIGITS) full_runs++;
    for (int k = n - 1; k >= 0; k--) begin
      d.digit_char = ASCII_ZERO + char_t'(dec[k]);
      d.last_digit = (k == 0);
      digits_due.push_back(d);
    end
  endfunction

  task automatic check_digit(input char_t ch, input logic last);
    digit_t want;
    if (digits_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: unexpected digit 0x%0h last=%0b", $realtime, ch, last);
    end else begin
      want = digits_due.pop_front();
      digits_checked++;
      if (ch !== want.digit_char || last !== want.last_digit) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: digit mismatch: expected 0x%0h last=%0b, got 0x%0h last=%0b",
                   $realtime, want.digit_char, want.last_digit, ch, last);
      end
    end
  endtask

  // Pause at random, but never inside the calm stretch
  function automatic bit take_break();
    if (values_taken >= 120 && values_taken < 200) return 1'b0;
    return $urandom_range(99) < 12;
  endfunction

  // Drive on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_bus.valid || value_taken) begin
        if (values_queued.size() != 0 && !take_break()) begin
          in_bus.valid <= 1'b1;
          in_bus.value <= values_queued.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= !take_break();
    end
  end

  // Sample on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_taken  <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      value_taken <= in_bus.valid && in_bus.ready;
      if (out_bus.valid && out_bus.ready) check_digit(out_bus.digit_char, out_bus.last_digit);
      if (in_bus.valid && in_bus.ready) begin
        expand_decimal(in_bus.value);
        values_taken++;
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    value_t      pow10[NUM_DIGITS];
    value_t      v;
    int          w;
    int          pick;
    int          k;
    int unsigned n_values;

    in_bus.valid  = 1'b0;
    in_bus.value  = '0;
    out_bus.ready = 1'b0;

    pow10[0] = 64'd1;
    for (int i = 1; i < NUM_DIGITS; i++) pow10[i] = pow10[i-1] * 10;

    // Corner values: zero, single digits, digit-count boundaries, bit patterns
    values_queued = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd12345,
                      64'hFFFF_FFFF, 64'h1_0000_0000,
                      64'd999999999999999999, 64'd1000000000000000000,
                      64'd9999999999999999999, 64'd10000000000000000000,
                      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                      64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                      64'h5555_5555_5555_5555, 64'h0123_4567_89AB_CDEF,
                      64'hFEDC_BA98_7654_3210, 64'd0};

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // random width, top bit set so digit counts spread evenly
        w = $urandom_range(1, 64);
        v = {$urandom, $urandom};
        if (w < 64) v = v & ((64'd1 << w) - 1);
        v[w-1] = 1'b1;
      end else if (pick < 60) begin
        v = {$urandom, $urandom};
      end else if (pick < 75) begin
        v = value_t'($urandom_range(999));
      end else if (pick < 90) begin
        k = $urandom_range(1, NUM_DIGITS - 1);
        v = pow10[k] + value_t'($urandom_range(4)) - 64'd2;
      end else begin
        v = value_t'('1) - value_t'($urandom_range(15));
      end
      values_queued.push_back(v);
    end
    n_values = values_queued.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait until every value is taken and all its digits have arrived
    wait (values_taken == n_values);
    wait (digits_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (digits_due.size() != 0) begin
      $display("%0d expected digits never arrived", digits_due.size());
      mismatches += digits_due.size();
    end

    $display("Converted %0d values (%0d zero, %0d with the full %0d digits), %0d digits checked",
             values_taken, zero_values, full_runs, NUM_DIGITS, digits_checked);
    $display("Digit mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
